/* rtl/core/assert_macros.svh */
// Assertion helpers shared by the RTL modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The condition must never hold at a clock edge outside reset.
`define TGBE_ASSERT_NEVER(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("assertion failed: condition must never hold");

// Whenever the antecedent holds, the consequent must hold in the same cycle.
`define TGBE_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: implication violated");

`endif

/* rtl/core/tgbe_pkg.sv */
`default_nettype none
package tgbe_pkg;

   localparam int PAGE_W   = 3;
   localparam int COL_W    = 7;
   localparam int GLYPH_IDX_W = 7;
   localparam int STEP_W   = 4;
   localparam int QUEUE_DEPTH = 2;

   localparam logic [7:0] FIRST_CODE   = 8'h20;
   localparam logic [7:0] LAST_CODE    = 8'h7E;
   localparam logic [7:0] NEWLINE_CODE = 8'h0A;
   localparam logic [GLYPH_IDX_W-1:0] QUESTION_IDX = 7'h1F;
   localparam int GLYPH_PITCH = 6;

   localparam logic [7:0] CMD_PAGE   = 8'hB0;
   localparam logic [7:0] CMD_COL_HI = 8'h10;
   localparam logic [7:0] SPACER     = 8'h00;

   localparam logic ACTION_DRAW = 1'b0;
   localparam logic ACTION_HOME = 1'b1;

   localparam logic [STEP_W-1:0] STEP_PAGE        = 4'd0;
   localparam logic [STEP_W-1:0] STEP_COL_LO      = 4'd1;
   localparam logic [STEP_W-1:0] STEP_COL_HI      = 4'd2;
   localparam logic [STEP_W-1:0] STEP_GLYPH_FIRST = 4'd3;
   localparam logic [STEP_W-1:0] STEP_GLYPH_LAST  = 4'd7;
   localparam logic [STEP_W-1:0] STEP_SPACER      = 4'd8;

   typedef struct packed {
      logic                   has_cursor;
      logic                   has_glyph;
      logic [PAGE_W-1:0]      page;
      logic [COL_W-1:0]       col;
      logic [GLYPH_IDX_W-1:0] glyph;
   } job_type;

   // One row per printable code, first column in the top byte.
   localparam int GLYPH_COUNT = 95;
   localparam logic [39:0] GLYPH_ROM [GLYPH_COUNT] = '{
      40'h0000000000, 40'h00005F0000, 40'h0007000700, 40'h147F147F14, 40'h242A7F2A12,
      40'h2313086462, 40'h3649552250, 40'h0005030000, 40'h001C224100, 40'h0041221C00,
      40'h082A1C2A08, 40'h08083E0808, 40'h0050300000, 40'h0808080808, 40'h0060600000,
      40'h2010080402, 40'h3E5149453E, 40'h00427F4000, 40'h4261514946, 40'h2141454B31,
      40'h1814127F10, 40'h2745454539, 40'h3C4A494930, 40'h0171090503, 40'h3649494936,
      40'h064949291E, 40'h0036360000, 40'h0056360000, 40'h0008142241, 40'h1414141414,
      40'h4122140800, 40'h0201510906, 40'h324979413E, 40'h7E1111117E, 40'h7F49494936,
      40'h3E41414122, 40'h7F4141221C, 40'h7F49494941, 40'h7F09090101, 40'h3E41415132,
      40'h7F0808087F, 40'h00417F4100, 40'h2040413F01, 40'h7F08142241, 40'h7F40404040,
      40'h7F0204027F, 40'h7F0408107F, 40'h3E4141413E, 40'h7F09090906, 40'h3E4151215E,
      40'h7F09192946, 40'h4649494931, 40'h01017F0101, 40'h3F4040403F, 40'h1F2040201F,
      40'h7F2018207F, 40'h6314081463, 40'h0304780403, 40'h6151494543, 40'h00007F4141,
      40'h0204081020, 40'h41417F0000, 40'h0402010204, 40'h4040404040, 40'h0001020400,
      40'h2054545478, 40'h7F48444438, 40'h3844444420, 40'h384444487F, 40'h3854545418,
      40'h087E090102, 40'h081454543C, 40'h7F08040478, 40'h00447D4000, 40'h2040443D00,
      40'h007F102844, 40'h00417F4000, 40'h7C04180478, 40'h7C08040478, 40'h3844444438,
      40'h7C14141408, 40'h081414187C, 40'h7C08040408, 40'h4854545420, 40'h043F444020,
      40'h3C4040207C, 40'h1C2040201C, 40'h3C4030403C, 40'h4428102844, 40'h0C5050503C,
      40'h4464544C44, 40'h0008364100, 40'h00007F0000, 40'h0041360800, 40'h0804081008
   };

   function automatic logic [39:0] glyph_row(input logic [GLYPH_IDX_W-1:0] idx);
      logic [39:0] row;
      row = '0;
      if (int'(idx) < GLYPH_COUNT) begin
         row = GLYPH_ROM[idx];
      end
      return row;
   endfunction

endpackage
`default_nettype wire

/* rtl/core/text_glyph_byte_emitter.sv */
`default_nettype none
// Character to display byte stream emitter for a page-addressed monochrome panel.
// Input channel req_*: one transaction per character or home request. tuser is
// the action (0 draw, 1 home), tdata the character code.
// Result channel rsp_*: one transaction per byte for the display. tuser is set
// for display RAM bytes and clear for commands, tdata[7:0] is the byte, tdata[8]
// closes one bus message and tlast marks the final byte caused by an input.
// A home or newline gives three cursor commands, a character gives five glyph
// columns and a blank column, preceded by three cursor commands when it wraps.
// The front stage classifies each input and moves the cursor in the cycle it is
// accepted; a two-entry job queue feeds the back stage, which issues one byte
// per cycle into the output register while the receiver takes bytes. An input
// is queued when accepted and its first byte is then registered in the output
// register; its byte count sets the sustained rate. When the receiver stalls, the
// output register holds its byte and the queue absorbs up to two further inputs
// before req_tready falls. Reset puts the cursor at page 0, column 0 and
// empties the queue and the output register.
module text_glyph_byte_emitter #(
   parameter int COLUMNS = 128,
   parameter int PAGES   = 8
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic        req_tuser,   // [0] action
   input  wire logic [7:0]  req_tdata,   // [7:0] character
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic             rsp_tuser,   // [0] is_data
   output logic [15:0]      rsp_tdata,   // [7:0] byte_value, [8] transfer_end, rest zero
   output logic             rsp_tlast
);

   tgbe_pkg::job_type push_job, head_job;
   logic push, full, pop, head_valid;

   tgbe_front #(
      .COLUMNS(COLUMNS),
      .PAGES  (PAGES)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tuser (req_tuser),
      .req_tdata (req_tdata),
      .queue_full(full),
      .push      (push),
      .job       (push_job)
   );

   tgbe_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_job  (push_job),
      .full      (full),
      .pop       (pop),
      .head_valid(head_valid),
      .head_job  (head_job)
   );

   tgbe_back u_back (
      .clock     (clock),
      .reset     (reset),
      .head_valid(head_valid),
      .head_job  (head_job),
      .pop       (pop),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tuser (rsp_tuser),
      .rsp_tdata (rsp_tdata),
      .rsp_tlast (rsp_tlast)
   );

endmodule
`default_nettype wire

/* rtl/core/tgbe_front.sv */
`default_nettype none
module tgbe_front #(
   parameter int COLUMNS = 128,
   parameter int PAGES   = 8
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_tvalid,
   output logic                  req_tready,
   input  wire logic             req_tuser,
   input  wire logic [7:0]       req_tdata,
   input  wire logic             queue_full,
   output logic                  push,
   output tgbe_pkg::job_type     job
);

   logic [tgbe_pkg::PAGE_W-1:0] page_ff, page_in;
   logic [tgbe_pkg::COL_W-1:0]  col_ff, col_in;
   logic [tgbe_pkg::PAGE_W-1:0] next_page;
   logic                        printable;
   logic                        wrap;

   assign req_tready = !queue_full;
   assign push       = req_tvalid && req_tready;

   always_comb begin
      next_page = page_ff + 3'd1;
      if ((4'(page_ff) + 4'd1) >= 4'(PAGES)) begin
         next_page = '0;
      end
      printable = req_tdata inside {[tgbe_pkg::FIRST_CODE:tgbe_pkg::LAST_CODE]};
      wrap = (9'(col_ff) + 9'(tgbe_pkg::GLYPH_PITCH)) > 9'(COLUMNS);

      job.has_cursor = 1'b1;
      job.has_glyph  = 1'b0;
      job.page       = '0;
      job.col        = '0;
      job.glyph      = printable ? 7'(req_tdata - tgbe_pkg::FIRST_CODE)
                                 : tgbe_pkg::QUESTION_IDX;
      page_in = page_ff;
      col_in  = col_ff;

      if (req_tuser == tgbe_pkg::ACTION_HOME) begin
         page_in = '0;
         col_in  = '0;
      end else if (req_tdata == tgbe_pkg::NEWLINE_CODE) begin
         job.page = next_page;
         page_in  = next_page;
         col_in   = '0;
      end else begin
         // A character that would run past the right edge starts a new line first.
         job.has_cursor = wrap;
         job.has_glyph  = 1'b1;
         job.page       = next_page;
         page_in        = wrap ? next_page : page_ff;
         col_in         = (wrap ? 7'd0 : col_ff) + 7'(tgbe_pkg::GLYPH_PITCH);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         page_ff <= '0;
         col_ff  <= '0;
      end else if (push) begin
         page_ff <= page_in;
         col_ff  <= col_in;
      end
   end

endmodule
`default_nettype wire

/* rtl/core/tgbe_queue.sv */
`default_nettype none
`include "assert_macros.svh"
module tgbe_queue (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               push,
   input  wire tgbe_pkg::job_type  push_job,
   output logic                    full,
   input  wire logic               pop,
   output logic                    head_valid,
   output tgbe_pkg::job_type       head_job
);

   localparam int PTR_W = $clog2(tgbe_pkg::QUEUE_DEPTH);
   localparam int CNT_W = $clog2(tgbe_pkg::QUEUE_DEPTH + 1);

   tgbe_pkg::job_type  entry_ff [tgbe_pkg::QUEUE_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0]   count_ff, count_in;

   assign full       = (count_ff == CNT_W'(tgbe_pkg::QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_job   = entry_ff[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

   `TGBE_ASSERT_NEVER(a_no_overflow, clock, reset, push && full)
   `TGBE_ASSERT_NEVER(a_no_underflow, clock, reset, pop && !head_valid)

endmodule
`default_nettype wire

/* rtl/core/tgbe_back.sv */
`default_nettype none
`include "assert_macros.svh"
module tgbe_back (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               head_valid,
   input  wire tgbe_pkg::job_type  head_job,
   output logic                    pop,
   output logic                    rsp_tvalid,
   input  wire logic               rsp_tready,
   output logic                    rsp_tuser,
   output logic [15:0]             rsp_tdata,
   output logic                    rsp_tlast
);

   logic [tgbe_pkg::STEP_W-1:0] step_ff, cur_step;
   logic        rsp_valid_ff;
   logic        is_data_ff, is_data_in;
   logic [7:0]  byte_ff, byte_in;
   logic        end_ff, end_in;
   logic        last_ff, last_in;
   logic [39:0] row;
   logic        load;

   assign load = head_valid && (!rsp_valid_ff || rsp_tready);
   assign pop  = load && last_in;

   always_comb begin
      // A job without cursor commands starts straight at the first glyph column.
      cur_step = head_job.has_cursor ? step_ff : step_ff + tgbe_pkg::STEP_GLYPH_FIRST;
      row      = tgbe_pkg::glyph_row(head_job.glyph);
      last_in  = head_job.has_glyph ? (cur_step == tgbe_pkg::STEP_SPACER)
                                    : (cur_step == tgbe_pkg::STEP_COL_HI);
      is_data_in = (cur_step >= tgbe_pkg::STEP_GLYPH_FIRST);
      end_in     = (cur_step <= tgbe_pkg::STEP_COL_HI) ||
                   (cur_step == tgbe_pkg::STEP_GLYPH_LAST) ||
                   (cur_step == tgbe_pkg::STEP_SPACER);
      case (cur_step)
         tgbe_pkg::STEP_PAGE:        byte_in = tgbe_pkg::CMD_PAGE | 8'(head_job.page);
         tgbe_pkg::STEP_COL_LO:      byte_in = {4'd0, head_job.col[3:0]};
         tgbe_pkg::STEP_COL_HI:      byte_in = tgbe_pkg::CMD_COL_HI | 8'(head_job.col[6:4]);
         tgbe_pkg::STEP_GLYPH_FIRST: byte_in = row[39:32];
         tgbe_pkg::STEP_GLYPH_FIRST + 4'd1: byte_in = row[31:24];
         tgbe_pkg::STEP_GLYPH_FIRST + 4'd2: byte_in = row[23:16];
         tgbe_pkg::STEP_GLYPH_FIRST + 4'd3: byte_in = row[15:8];
         tgbe_pkg::STEP_GLYPH_LAST:  byte_in = row[7:0];
         default:                    byte_in = tgbe_pkg::SPACER;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (load) begin
            step_ff <= last_in ? '0 : step_ff + 4'd1;
         end
         if (load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         is_data_ff <= is_data_in;
         byte_ff    <= byte_in;
         end_ff     <= end_in;
         last_ff    <= last_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = is_data_ff;
   assign rsp_tdata  = {7'd0, end_ff, byte_ff};
   assign rsp_tlast  = last_ff;

   `TGBE_ASSERT_IMPLIES(a_last_ends_message, clock, reset, rsp_valid_ff && last_ff, end_ff)
   `TGBE_ASSERT_NEVER(a_step_in_range, clock, reset,
      head_valid && (cur_step > tgbe_pkg::STEP_SPACER))

endmodule
`default_nettype wire

/* bench/tb.sv */
`timescale 1ns / 1ps
`default_nettype none
module tb;

   localparam int COLUMNS      = 128;
   localparam int PAGES        = 8;
   localparam int STALL_LIMIT  = 1000;
   localparam int HOLD_CYCLES  = 150;
   localparam int DRAIN_CYCLES = 12;
   localparam logic [7:0] SUBST_CODE = 8'h3F;

   // 5x8 font, one row per printable code, leftmost column in the top byte.
   localparam logic [39:0] GLYPH_FONT [95] = '{
      40'h0000000000, 40'h00005F0000, 40'h0007000700, 40'h147F147F14, 40'h242A7F2A12,
      40'h2313086462, 40'h3649552250, 40'h0005030000, 40'h001C224100, 40'h0041221C00,
      40'h082A1C2A08, 40'h08083E0808, 40'h0050300000, 40'h0808080808, 40'h0060600000,
      40'h2010080402, 40'h3E5149453E, 40'h00427F4000, 40'h4261514946, 40'h2141454B31,
      40'h1814127F10, 40'h2745454539, 40'h3C4A494930, 40'h0171090503, 40'h3649494936,
      40'h064949291E, 40'h0036360000, 40'h0056360000, 40'h0008142241, 40'h1414141414,
      40'h4122140800, 40'h0201510906, 40'h324979413E, 40'h7E1111117E, 40'h7F49494936,
      40'h3E41414122, 40'h7F4141221C, 40'h7F49494941, 40'h7F09090101, 40'h3E41415132,
      40'h7F0808087F, 40'h00417F4100, 40'h2040413F01, 40'h7F08142241, 40'h7F40404040,
      40'h7F0204027F, 40'h7F0408107F, 40'h3E4141413E, 40'h7F09090906, 40'h3E4151215E,
      40'h7F09192946, 40'h4649494931, 40'h01017F0101, 40'h3F4040403F, 40'h1F2040201F,
      40'h7F2018207F, 40'h6314081463, 40'h0304780403, 40'h6151494543, 40'h00007F4141,
      40'h0204081020, 40'h41417F0000, 40'h0402010204, 40'h4040404040, 40'h0001020400,
      40'h2054545478, 40'h7F48444438, 40'h3844444420, 40'h384444487F, 40'h3854545418,
      40'h087E090102, 40'h081454543C, 40'h7F08040478, 40'h00447D4000, 40'h2040443D00,
      40'h007F102844, 40'h00417F4000, 40'h7C04180478, 40'h7C08040478, 40'h3844444438,
      40'h7C14141408, 40'h081414187C, 40'h7C08040408, 40'h4854545420, 40'h043F444020,
      40'h3C4040207C, 40'h1C2040201C, 40'h3C4030403C, 40'h4428102844, 40'h0C5050503C,
      40'h4464544C44, 40'h0008364100, 40'h00007F0000, 40'h0041360800, 40'h0804081008
   };

   typedef struct packed {
      logic       is_data;
      logic [7:0] value;
      logic       msg_end;
      logic       item_end;
   } disp_byte_type;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic        req_tuser  = tgbe_pkg::ACTION_DRAW;   // [0] action
   logic [7:0]  req_tdata  = 8'h00;                   // [7:0] character
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic        rsp_tuser;                            // [0] is_data
   logic [15:0] rsp_tdata;                            // [7:0] byte_value, [8] transfer_end
   logic        rsp_tlast;

   // Display cursor as the block should hold it.
   logic [2:0]  page_pos = '0;
   logic [6:0]  col_pos  = '0;

   disp_byte_type pending_bytes[$];
   disp_byte_type burst [9];
   int            burst_len;

   bit          tx_gaps      = 1'b1;
   bit          rx_gaps      = 1'b1;
   int          holds_asked  = 0;
   int          holds_served = 0;
   int          hold_left    = 0;
   int          quiet_cycles = 0;
   int          error_count  = 0;
   int          items_sent   = 0;
   int          bytes_seen   = 0;
   int          line_wraps   = 0;
   int          page_wraps   = 0;

   text_glyph_byte_emitter #(
      .COLUMNS(COLUMNS),
      .PAGES  (PAGES)
   ) u_top (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tuser (req_tuser),
      .req_tdata (req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tuser (rsp_tuser),
      .rsp_tdata (rsp_tdata),
      .rsp_tlast (rsp_tlast)
   );

   always #2 clock = ~clock;

   function automatic void flag_error(input string msg);
      error_count++;
      if (error_count <= 10) begin
         $display("%s", msg);
      end
   endfunction

   function automatic void add_byte(input logic is_data, input logic [7:0] value,
                                    input logic msg_end);
      burst[burst_len] = '{is_data, value, msg_end, 1'b0};
      burst_len++;
   endfunction

   function automatic void add_cursor_cmds();
      add_byte(1'b0, tgbe_pkg::CMD_PAGE | {5'b0, page_pos}, 1'b1);
      add_byte(1'b0, {4'h0, col_pos[3:0]}, 1'b1);
      add_byte(1'b0, tgbe_pkg::CMD_COL_HI | {5'b0, col_pos[6:4]}, 1'b1);
   endfunction

   function automatic void advance_line();
      if (int'(page_pos) + 1 >= PAGES) begin
         page_pos = '0;
         page_wraps++;
      end else begin
         page_pos = page_pos + 3'd1;
      end
      col_pos = '0;
   endfunction

   // Works out the bytes one transaction should produce and queues them.
   function automatic void render_char(input logic action, input logic [7:0] code);
      logic [7:0]  shown;
      logic [39:0] cols;
      burst_len = 0;
      if (action == tgbe_pkg::ACTION_HOME) begin
         page_pos = '0;
         col_pos  = '0;
         add_cursor_cmds();
      end else if (code == tgbe_pkg::NEWLINE_CODE) begin
         advance_line();
         add_cursor_cmds();
      end else begin
         shown = (code inside {[tgbe_pkg::FIRST_CODE:tgbe_pkg::LAST_CODE]}) ? code
                                                                            : SUBST_CODE;
         if (int'(col_pos) + tgbe_pkg::GLYPH_PITCH > COLUMNS) begin
            line_wraps++;
            advance_line();
            add_cursor_cmds();
         end
         cols = GLYPH_FONT[int'(shown - tgbe_pkg::FIRST_CODE)];
         for (int i = 0; i < 5; i++) begin
            add_byte(1'b1, cols[39 - 8*i -: 8], i == 4);
         end
         add_byte(1'b1, tgbe_pkg::SPACER, 1'b1);
         col_pos = col_pos + 7'(tgbe_pkg::GLYPH_PITCH);
      end
      burst[burst_len-1].item_end = 1'b1;
      for (int i = 0; i < burst_len; i++) begin
         pending_bytes.push_back(burst[i]);
      end
   endfunction

   task automatic send_item(input logic action, input logic [7:0] code);
      if (tx_gaps && $urandom_range(0, 4) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 18)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= action;
      req_tdata  <= code;
      render_char(action, code);
      items_sent++;
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic send_random_item();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 3) begin
         send_item(tgbe_pkg::ACTION_HOME, 8'($urandom_range(0, 255)));
      end else if (pick < 6) begin
         send_item(tgbe_pkg::ACTION_DRAW, tgbe_pkg::NEWLINE_CODE);
      end else if (pick < 14) begin
         send_item(tgbe_pkg::ACTION_DRAW, 8'($urandom_range(0, 255)));
      end else begin
         send_item(tgbe_pkg::ACTION_DRAW,
                   8'($urandom_range(tgbe_pkg::FIRST_CODE, tgbe_pkg::LAST_CODE)));
      end
   endtask

   // Home ignores the character field; newline only moves the cursor.
   task automatic test_cursor_commands();
      send_item(tgbe_pkg::ACTION_HOME, 8'hFF);
      send_item(tgbe_pkg::ACTION_DRAW, tgbe_pkg::NEWLINE_CODE);
      send_item(tgbe_pkg::ACTION_HOME, tgbe_pkg::NEWLINE_CODE);
      send_item(tgbe_pkg::ACTION_DRAW, tgbe_pkg::NEWLINE_CODE);
   endtask

   // Printable extremes and two other printable codes, and codes that must fall back to the question mark.
   task automatic test_glyph_codes();
      logic [7:0] codes [11] = '{8'h20, 8'h7E, 8'h41, SUBST_CODE, 8'h1F, 8'h7F,
                                 8'h00, 8'h80, 8'hFF, 8'h09, 8'h0B};
      foreach (codes[i]) begin
         send_item(tgbe_pkg::ACTION_DRAW, codes[i]);
      end
   endtask

   task automatic test_page_wrap();
      send_item(tgbe_pkg::ACTION_HOME, 8'h00);
      repeat (PAGES) send_item(tgbe_pkg::ACTION_DRAW, tgbe_pkg::NEWLINE_CODE);
   endtask

   // A full line of text, so that the width check forces a wrap.
   task automatic test_line_fill();
      send_item(tgbe_pkg::ACTION_HOME, 8'h55);
      repeat (COLUMNS / tgbe_pkg::GLYPH_PITCH + 4) begin
         send_item(tgbe_pkg::ACTION_DRAW,
                   8'($urandom_range(tgbe_pkg::FIRST_CODE, tgbe_pkg::LAST_CODE)));
      end
   endtask

   task automatic test_random_text(input int count);
      repeat (count) send_random_item();
   endtask

   // The receiver holds off for a long stretch so that the input side stalls.
   task automatic test_backpressure();
      holds_asked++;
      repeat (12) send_item(tgbe_pkg::ACTION_DRAW, 8'($urandom_range(0, 255)));
   endtask

   task automatic test_full_rate();
      tx_gaps = 1'b0;
      rx_gaps = 1'b0;
      repeat (24) send_random_item();
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (holds_served != holds_asked) begin
         holds_served <= holds_asked;
         hold_left    <= HOLD_CYCLES - 1;
         rsp_tready   <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left  <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else if (rx_gaps && $urandom_range(0, 5) == 0) begin
         hold_left  <= $urandom_range(0, 17);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   always @(posedge clock) begin : check_bytes
      disp_byte_type got;
      disp_byte_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = '{rsp_tuser, rsp_tdata[7:0], rsp_tdata[8], rsp_tlast};
         bytes_seen++;
         if (pending_bytes.size() == 0) begin
            flag_error($sformatf({"byte %0d arrived with nothing pending:",
                                  " data=%b value=%h end=%b last=%b"},
                                 bytes_seen, got.is_data, got.value, got.msg_end,
                                 got.item_end));
         end else begin
            want = pending_bytes.pop_front();
            if (got !== want) begin
               flag_error($sformatf({"byte %0d mismatch: expected data=%b value=%h end=%b last=%b,",
                                     " got data=%b value=%h end=%b last=%b"},
                                    bytes_seen, want.is_data, want.value, want.msg_end,
                                    want.item_end, got.is_data, got.value, got.msg_end,
                                    got.item_end));
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("Timeout: no transaction for %0d cycles, %0d bytes outstanding",
                  quiet_cycles, pending_bytes.size());
         $display("Test completed with failures");
         $finish;
      end
   end

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_cursor_commands();
      test_glyph_codes();
      test_page_wrap();
      test_line_fill();
      test_random_text(64);
      test_backpressure();
      test_full_rate();
      req_tvalid <= 1'b0;
      while (pending_bytes.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("Sent %0d characters and home requests, checked %0d display bytes.",
               items_sent, bytes_seen);
      $display("Width wraps: %0d, page wraps: %0d, mismatches: %0d.",
               line_wraps, page_wraps, error_count);
      if (error_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
`default_nettype wire

/* files.f */
+incdir+rtl/core
rtl/core/tgbe_pkg.sv
rtl/core/tgbe_front.sv
rtl/core/tgbe_queue.sv
rtl/core/tgbe_back.sv
rtl/core/text_glyph_byte_emitter.sv
bench/tb.sv
